// File: rtl/clkr_pkg.sv
// ----------------------------------------------------------------------------
// clkr_pkg
// Types and constants for the second-chance victim selector.
// ----------------------------------------------------------------------------
`default_nettype none

package clkr_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int NUM_POOLS_DEF   = 2;

  localparam int REQ_TYPE_W  = 2;
  localparam int ENTRY_IDX_W = 6;
  localparam int CNT_REG_W   = 7;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CNT_REG_W-1:0] CNT_RESET = 7'd64;

  localparam logic [REQ_TYPE_W-1:0] REQ_REFERENCE = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_PIN       = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_ALLOCATE  = 2'd2;

  localparam logic REG_PAGE_CNT  = 1'b0;
  localparam logic REG_TRAIN_CNT = 1'b1;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_NONE  = 1'b1;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0]  req_type;
    logic                   pool_select;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   mark_dirty;
    logic                   pin_value;
  } req_t;

  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] victim_index;
    logic                   flush_needed;
    logic                   alloc_status;
  } rsp_t;

  typedef struct packed {
    logic pinned;
    logic referenced;
    logic dirty;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/clock_second_chance_replacer.sv
// ----------------------------------------------------------------------------
// clock_second_chance_replacer
// Clock (second-chance) victim selection over buffer pools; per-entry flags
// live in one synchronous memory, one hand register per pool.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                       | item
//  req     | in  | req_valid / req_stall           | clkr_pkg::req_t
//  rsp     | out | rsp_valid / rsp_stall           | clkr_pkg::rsp_t
//  apb     | in  | psel, penable, pwrite, pready=1 | 2 count registers
//
//  Reference and pin items read the entry, then modify it and write it back.
//  Allocate visits k entries (1 to 2*count, none for a pool out of range),
//  one entry per cycle through the single memory read port.
//  After reset a clearing pass writes all 2**(pool bits + index bits) entries
//  (128 at defaults) while req_stall is high.
//  A stalled result holds the allocate in S_DONE with req_stall high.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_second_chance_replacer #(
  parameter int MAX_ENTRIES = clkr_pkg::MAX_ENTRIES_DEF,
  parameter int NUM_POOLS   = clkr_pkg::NUM_POOLS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 req_valid,
  output logic                                req_stall,
  input  clkr_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  wire                                 rsp_stall,
  output clkr_pkg::rsp_t                      rsp,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [clkr_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire  [clkr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [clkr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int AW    = PW + IW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int SW    = CW + 1;
  localparam int CXW   = (CW > clkr_pkg::CNT_REG_W) ? CW : clkr_pkg::CNT_REG_W;
  localparam int VW    = clkr_pkg::ENTRY_IDX_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RMW   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  function automatic logic [CW-1:0] clamp_cnt(input logic [clkr_pkg::CNT_REG_W-1:0] r);
    logic [CXW-1:0] x;
    x = CXW'(r);
    if (x == '0) begin
      return CW'(1);
    end else if (x > CXW'(MAX_ENTRIES)) begin
      return CW'(MAX_ENTRIES);
    end
    return CW'(x);
  endfunction

  function automatic logic [IW-1:0] nxt_idx(input logic [IW-1:0] i, input logic [CW-1:0] n);
    logic [CW-1:0] s;
    s = CW'(i) + CW'(1);
    return (s < n) ? IW'(s) : '0;
  endfunction

  // memory
  clkr_pkg::entry_t mem [DEPTH];
  clkr_pkg::entry_t rdata;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    rd_addr;
  clkr_pkg::entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // registers
  logic [2:0]                     state, state_next;
  logic [AW-1:0]                  clr_addr;
  logic [PW-1:0]                  pl;
  logic [clkr_pkg::REQ_TYPE_W-1:0] rq_type;
  logic                           rq_dirty;
  logic                           rq_pin;
  logic [IW-1:0]                  e_idx, e_idx_next;
  logic [SW-1:0]                  steps, steps_next;
  clkr_pkg::rsp_t                 res, res_next;
  logic                           fwd_hit;
  clkr_pkg::entry_t               fwd_data;
  logic [IW-1:0]                  hands [NUM_POOLS];
  logic                           hand_we;
  logic [IW-1:0]                  hand_next;
  logic [clkr_pkg::CNT_REG_W-1:0] page_cnt, train_cnt;

  logic             acc;
  logic             pool_ok;
  logic             idx_ok;
  logic [PW-1:0]    pool_in;
  logic [CW-1:0]    n_act;
  logic [IW-1:0]    start_idx;
  logic [IW-1:0]    sweep_nxt;
  clkr_pkg::entry_t ent;
  logic             last_step;
  logic             rsp_load;

  assign pready    = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign acc       = req_valid && (state == S_IDLE);
  assign pool_ok   = 32'(req.pool_select) < NUM_POOLS;
  assign idx_ok    = 32'(req.entry_index) < MAX_ENTRIES;
  assign pool_in   = PW'(req.pool_select);
  assign n_act     = (pl == '0) ? clamp_cnt(page_cnt) : clamp_cnt(train_cnt);
  assign start_idx = (CW'(hands[pl]) >= n_act) ? '0 : hands[pl];
  assign sweep_nxt = nxt_idx(e_idx, n_act);
  assign ent       = fwd_hit ? fwd_data : rdata;
  assign last_step = (steps + SW'(1)) == {n_act, 1'b0};
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = {pl, e_idx};
    wdata      = '0;
    rd_addr    = {pool_in, IW'(req.entry_index)};
    e_idx_next = e_idx;
    steps_next = steps;
    res_next   = res;
    hand_we    = 1'b0;
    hand_next  = nxt_idx(e_idx, n_act);
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          res_next = '{victim_index: '0, flush_needed: 1'b0,
                       alloc_status: clkr_pkg::STATUS_NONE};
          e_idx_next = IW'(req.entry_index);
          case (req.req_type)
            clkr_pkg::REQ_REFERENCE, clkr_pkg::REQ_PIN: begin
              if (pool_ok && idx_ok) begin
                state_next = S_RMW;
              end
            end
            clkr_pkg::REQ_ALLOCATE: begin
              state_next = pool_ok ? S_START : S_DONE;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RMW: begin
        we    = 1'b1;
        wdata = ent;
        if (rq_type == clkr_pkg::REQ_REFERENCE) begin
          wdata.referenced = 1'b1;
          wdata.dirty      = ent.dirty | rq_dirty;
        end else begin
          wdata.pinned = rq_pin;
        end
        state_next = S_IDLE;
      end
      S_START: begin
        rd_addr    = {pl, start_idx};
        e_idx_next = start_idx;
        steps_next = '0;
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        rd_addr = {pl, sweep_nxt};
        if (!ent.pinned && !ent.referenced) begin
          we         = 1'b1;
          hand_we    = 1'b1;
          res_next   = '{victim_index: VW'(e_idx), flush_needed: ent.dirty,
                         alloc_status: clkr_pkg::STATUS_FOUND};
          state_next = S_DONE;
        end else begin
          if (!ent.pinned) begin
            we    = 1'b1;
            wdata = '{pinned: 1'b0, referenced: 1'b0, dirty: ent.dirty};
          end
          if (last_step) begin
            state_next = S_DONE;
          end else begin
            e_idx_next = sweep_nxt;
            steps_next = steps + SW'(1);
          end
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      fwd_hit   <= 1'b0;
      rsp_valid <= 1'b0;
      page_cnt  <= clkr_pkg::CNT_RESET;
      train_cnt <= clkr_pkg::CNT_RESET;
      for (int p = 0; p < NUM_POOLS; p++) begin
        hands[p] <= '0;
      end
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr + AW'(1);
      fwd_hit  <= we && (waddr == rd_addr);
      if (hand_we) begin
        hands[pl] <= hand_next;
      end
      if (psel && penable && pwrite) begin
        if (paddr[2] == clkr_pkg::REG_TRAIN_CNT) begin
          train_cnt <= pwdata[clkr_pkg::CNT_REG_W-1:0];
        end else begin
          page_cnt <= pwdata[clkr_pkg::CNT_REG_W-1:0];
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wdata;
    e_idx    <= e_idx_next;
    steps    <= steps_next;
    res      <= res_next;
    if (acc) begin
      pl       <= pool_in;
      rq_type  <= req.req_type;
      rq_dirty <= req.mark_dirty;
      rq_pin   <= req.pin_value;
    end
    if (rsp_load) begin
      rsp <= res;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == clkr_pkg::REG_TRAIN_CNT) begin
      prdata[clkr_pkg::CNT_REG_W-1:0] = train_cnt;
    end else begin
      prdata[clkr_pkg::CNT_REG_W-1:0] = page_cnt;
    end
  end

  // checks
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.alloc_status == clkr_pkg::STATUS_NONE)
      |-> (rsp.victim_index == '0) && !rsp.flush_needed)
    else $error("failed allocate carries victim data");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (steps < {n_act, 1'b0}))
    else $error("sweep ran past two passes");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (CW'(e_idx) < n_act))
    else $error("sweep outside active range");

  a_hand_move: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) && hand_we |=> (state == S_DONE)
      && (res.alloc_status == clkr_pkg::STATUS_FOUND))
    else $error("hand moved without a victim");

endmodule

`default_nettype wire
